@@ rtl/phts_pkg.sv @@
// shared types, constants and helper functions of the pipeline hazard scoreboard
// used by phts_table, phts_sched and pipeline_hazard_timing_scoreboard_core
// no dependencies
`default_nettype none

package phts_pkg;

    localparam int NUM_REGS  = 32;
    localparam int MAX_INSTR = 1024;

    localparam int REG_W  = $clog2(NUM_REGS);
    localparam int IDX_W  = $clog2(MAX_INSTR);
    localparam int CYC_W  = 16;
    localparam int NEED_W = CYC_W + 2;
    localparam int KIND_W = 2;
    localparam int STL_W  = 2;

    localparam logic [CYC_W-1:0] CYC_MAX   = {CYC_W{1'b1}};
    localparam logic [STL_W-1:0] STALL_MAX = {STL_W{1'b1}};
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_INSTR - 1);

    // instruction kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALU   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    // producer stage codes
    localparam logic [1:0] STAGE_EX = 2'd0;
    localparam logic [1:0] STAGE_MA = 2'd1;
    localparam logic [1:0] STAGE_WR = 2'd2;

    // tdata fields of an input transfer, last member lands in the lowest bits
    typedef struct packed {
        logic [REG_W-1:0] dest;
        logic             dest_valid;
        logic [REG_W-1:0] src_b;
        logic             src_b_valid;
        logic [REG_W-1:0] src_a;
        logic             src_a_valid;
        logic             new_program;
    } item_t;

    // one result transfer, last member lands in the lowest bits
    typedef struct packed {
        logic [1:0]       fwd_b_stage;
        logic [IDX_W-1:0] fwd_b_producer;
        logic             fwd_b_valid;
        logic [1:0]       fwd_a_stage;
        logic [IDX_W-1:0] fwd_a_producer;
        logic             fwd_a_valid;
        logic [CYC_W-1:0] write_cycle;
        logic [CYC_W-1:0] ex_cycle;
        logic [STL_W-1:0] stall_count;
        logic [CYC_W-1:0] fetch_cycle;
        logic [IDX_W-1:0] instr_index;
    } result_t;

    // last producer of one register
    typedef struct packed {
        logic [IDX_W-1:0]  producer_index;
        logic [CYC_W-1:0]  produce_cycle;
        logic [CYC_W-1:0]  write_cycle;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // table update from the scheduling stage
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [REG_W-1:0] addr;
        entry_t           entry;
    } tbl_wr_t;

    localparam int ITEM_W     = $bits(item_t);
    localparam int S_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int RES_W      = $bits(result_t);
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    function automatic logic [CYC_W-1:0] sat_cyc(input logic [CYC_W:0] v);
        sat_cyc = v[CYC_W] ? CYC_MAX : v[CYC_W-1:0];
    endfunction

    function automatic logic [STL_W-1:0] clamp_stall(input logic signed [NEED_W-1:0] need);
        logic signed [NEED_W-1:0] top;
        top = NEED_W'(signed'({1'b0, STALL_MAX}));
        if (need < 0)
            clamp_stall = '0;
        else if (need > top)
            clamp_stall = STALL_MAX;
        else
            clamp_stall = need[STL_W-1:0];
    endfunction

    function automatic logic [1:0] stage_of(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_LOAD: stage_of = STAGE_MA;
            KIND_ALU:  stage_of = STAGE_EX;
            default:   stage_of = STAGE_WR;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ rtl/phts_table.sv @@
// per-register producer table: valid flags in flops, entries in a small memory
// with two registered read ports and a bypass of the write in the same cycle
// depends on phts_pkg
`default_nettype none

module phts_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [phts_pkg::REG_W-1:0] rd_addr_a,
    input  wire logic [phts_pkg::REG_W-1:0] rd_addr_b,
    output phts_pkg::entry_t               rd_ent_a,
    output phts_pkg::entry_t               rd_ent_b,
    input  wire logic [phts_pkg::REG_W-1:0] look_addr_a,
    input  wire logic [phts_pkg::REG_W-1:0] look_addr_b,
    output logic                           look_a,
    output logic                           look_b,
    input  wire phts_pkg::tbl_wr_t         wr
);
    import phts_pkg::*;

    entry_t               mem [NUM_REGS];
    logic [NUM_REGS-1:0]  has_reg;
    logic [NUM_REGS-1:0]  has_next;
    entry_t               rd_a_reg;
    entry_t               rd_b_reg;
    entry_t               byp_ent_reg;
    logic                 byp_a_reg;
    logic                 byp_b_reg;

    always_comb
    begin
        has_next = wr.clear ? '0 : has_reg;
        if (wr.en)
        begin
            has_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg   <= '0;
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else
        begin
            has_reg <= has_next;
            if (rd_en)
            begin
                // the read sees the old entry when the predecessor writes it now
                byp_a_reg <= wr.en && (wr.addr == rd_addr_a);
                byp_b_reg <= wr.en && (wr.addr == rd_addr_b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_a_reg    <= mem[rd_addr_a];
            rd_b_reg    <= mem[rd_addr_b];
            byp_ent_reg <= wr.entry;
        end
    end

    assign rd_ent_a = byp_a_reg ? byp_ent_reg : rd_a_reg;
    assign rd_ent_b = byp_b_reg ? byp_ent_reg : rd_b_reg;
    assign look_a   = has_reg[look_addr_a];
    assign look_b   = has_reg[look_addr_b];

endmodule

`default_nettype wire

@@ rtl/phts_sched.sv @@
// single-pass scheduling logic: stalls, stage cycles, forwarding events and
// the table update for one instruction
// depends on phts_pkg
`default_nettype none

module phts_sched (
    input  wire phts_pkg::item_t             item,
    input  wire logic [phts_pkg::KIND_W-1:0] kind,
    input  wire logic                        fwd_en,
    input  wire logic                        look_a,
    input  wire logic                        look_b,
    input  wire phts_pkg::entry_t            ent_a,
    input  wire phts_pkg::entry_t            ent_b,
    input  wire logic [phts_pkg::CYC_W-1:0]  fetch_ptr,
    input  wire logic [phts_pkg::IDX_W-1:0]  index_ptr,
    output phts_pkg::result_t                res,
    output phts_pkg::tbl_wr_t                upd,
    output logic [phts_pkg::CYC_W-1:0]       fetch_ptr_next,
    output logic [phts_pkg::IDX_W-1:0]       index_ptr_next
);
    import phts_pkg::*;

    logic                     has_a;
    logic                     has_b;
    logic [CYC_W-1:0]         fetch;
    logic [IDX_W-1:0]         idx;
    logic signed [NEED_W-1:0] fetch_s;
    logic signed [NEED_W-1:0] need_a;
    logic signed [NEED_W-1:0] need_b;
    logic [STL_W-1:0]         stall_a;
    logic [STL_W-1:0]         stall_b;
    logic [STL_W-1:0]         stalls;
    logic [CYC_W:0]           base;
    logic [CYC_W-1:0]         rr;
    logic [CYC_W-1:0]         ex;
    logic [CYC_W-1:0]         ma;
    logic [CYC_W-1:0]         wb;
    logic                     ok_a;
    logic                     ok_b;

    always_comb
    begin
        // a new program sees an empty table
        has_a = item.src_a_valid && look_a && !item.new_program;
        has_b = item.src_b_valid && look_b && !item.new_program;
        fetch = item.new_program ? CYC_W'(1) : fetch_ptr;
        idx   = item.new_program ? '0 : index_ptr;

        fetch_s = NEED_W'(signed'({1'b0, fetch}));
        if (fwd_en)
        begin
            need_a = NEED_W'(signed'({1'b0, ent_a.produce_cycle})) - fetch_s - NEED_W'(1);
            need_b = NEED_W'(signed'({1'b0, ent_b.produce_cycle})) - fetch_s - NEED_W'(1);
        end
        else
        begin
            need_a = NEED_W'(signed'({1'b0, ent_a.write_cycle})) - fetch_s;
            need_b = NEED_W'(signed'({1'b0, ent_b.write_cycle})) - fetch_s;
        end
        stall_a = has_a ? clamp_stall(need_a) : '0;
        stall_b = has_b ? clamp_stall(need_b) : '0;
        stalls  = (stall_a > stall_b) ? stall_a : stall_b;

        base = {1'b0, fetch} + (CYC_W+1)'(stalls);
        rr   = sat_cyc(base + (CYC_W+1)'(1));
        ex   = sat_cyc(base + (CYC_W+1)'(2));
        ma   = sat_cyc(base + (CYC_W+1)'(3));
        wb   = sat_cyc(base + (CYC_W+1)'(4));

        ok_a = has_a && fwd_en
            && ({1'b0, ex} >= ({1'b0, ent_a.produce_cycle} + (CYC_W+1)'(1)))
            && (ent_a.write_cycle > rr);
        ok_b = has_b && fwd_en
            && ({1'b0, ex} >= ({1'b0, ent_b.produce_cycle} + (CYC_W+1)'(1)))
            && (ent_b.write_cycle > rr);
        // no second event for the same producer
        if (ok_a && (ent_a.producer_index == ent_b.producer_index))
        begin
            ok_b = 1'b0;
        end

        res                = '0;
        res.instr_index    = idx;
        res.fetch_cycle    = fetch;
        res.stall_count    = stalls;
        res.ex_cycle       = ex;
        res.write_cycle    = wb;
        if (ok_a)
        begin
            res.fwd_a_valid    = 1'b1;
            res.fwd_a_producer = ent_a.producer_index;
            res.fwd_a_stage    = stage_of(ent_a.kind);
        end
        if (ok_b)
        begin
            res.fwd_b_valid    = 1'b1;
            res.fwd_b_producer = ent_b.producer_index;
            res.fwd_b_stage    = stage_of(ent_b.kind);
        end

        upd                      = '0;
        upd.en                   = item.dest_valid;
        upd.clear                = item.new_program;
        upd.addr                 = item.dest;
        upd.entry.producer_index = idx;
        upd.entry.write_cycle    = wb;
        upd.entry.kind           = kind;
        case (kind)
            KIND_LOAD: upd.entry.produce_cycle = ma;
            KIND_ALU:  upd.entry.produce_cycle = ex;
            default:   upd.entry.produce_cycle = wb;
        endcase

        fetch_ptr_next = rr;
        index_ptr_next = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    end

endmodule

`default_nettype wire

@@ rtl/pipeline_hazard_timing_scoreboard_core.sv @@
// top level of the pipeline hazard scoreboard: input stage, result register,
// program counters and the forwarding configuration register
// depends on phts_pkg, phts_table and phts_sched
`default_nettype none

// One instruction in, one schedule out. The block takes a transfer in every
// cycle while the schedule stage is empty or can pass on its result. A first
// step reads the producer table at both source registers; the second, once the
// output side can take it, does the whole scheduling pass in one stage, loads
// the result register and updates the table and the fetch and index counters,
// so the next instruction sees this one's destination without a gap. The output
// register lets a new transfer in while a result still waits. No clearing pass
// after reset; a transfer with new_program set starts a fresh program at fetch cycle 1, index 0.

module pipeline_hazard_timing_scoreboard_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_wr_data,  // forwarding_enable
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // new_program, src_a_valid, src_a, src_b_valid, src_b, dest_valid, dest
    input  wire logic [phts_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [phts_pkg::KIND_W-1:0]     s_tuser,      // kind
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // instr_index, fetch_cycle, stall_count, ex_cycle, write_cycle,
    // fwd_a_valid, fwd_a_producer, fwd_a_stage,
    // fwd_b_valid, fwd_b_producer, fwd_b_stage
    output logic [phts_pkg::M_TDATA_W-1:0]       m_tdata
);
    import phts_pkg::*;

    logic              fwd_en_reg;
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic              m_valid_reg;
    result_t           res_reg;
    logic [CYC_W-1:0]  fetch_ptr_reg;
    logic [IDX_W-1:0]  index_ptr_reg;
    logic [CYC_W-1:0]  fetch_ptr_next;
    logic [IDX_W-1:0]  index_ptr_next;

    item_t             in_item;
    logic              accept;
    logic              advance;
    logic              look_a;
    logic              look_b;
    entry_t            ent_a;
    entry_t            ent_b;
    result_t           res_next;
    tbl_wr_t           upd;
    tbl_wr_t           tbl_wr;

    assign in_item  = item_t'(s_tdata[ITEM_W-1:0]);
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        tbl_wr       = upd;
        tbl_wr.en    = upd.en && advance;
        tbl_wr.clear = upd.clear && advance;
    end

    phts_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (accept),
        .rd_addr_a   (in_item.src_a),
        .rd_addr_b   (in_item.src_b),
        .rd_ent_a    (ent_a),
        .rd_ent_b    (ent_b),
        .look_addr_a (s1_item_reg.src_a),
        .look_addr_b (s1_item_reg.src_b),
        .look_a      (look_a),
        .look_b      (look_b),
        .wr          (tbl_wr)
    );

    phts_sched u_sched (
        .item           (s1_item_reg),
        .kind           (s1_kind_reg),
        .fwd_en         (fwd_en_reg),
        .look_a         (look_a),
        .look_b         (look_b),
        .ent_a          (ent_a),
        .ent_b          (ent_b),
        .fetch_ptr      (fetch_ptr_reg),
        .index_ptr      (index_ptr_reg),
        .res            (res_next),
        .upd            (upd),
        .fetch_ptr_next (fetch_ptr_next),
        .index_ptr_next (index_ptr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg    <= 1'b1;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fetch_ptr_reg <= CYC_W'(1);
            index_ptr_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fwd_en_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                m_valid_reg   <= 1'b1;
                fetch_ptr_reg <= fetch_ptr_next;
                index_ptr_reg <= index_ptr_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
            s1_kind_reg <= s_tuser;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(res_reg);

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg)
        else $error("input side held off with an empty schedule stage");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_valid_reg)
        else $error("scheduled transfer did not reach the result register");

    a_ex_before_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (res_reg.ex_cycle <= res_reg.write_cycle))
        else $error("writeback cycle earlier than execute cycle");

    a_no_duplicate_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && res_reg.fwd_a_valid && res_reg.fwd_b_valid)
            |-> (res_reg.fwd_a_producer != res_reg.fwd_b_producer))
        else $error("second forwarding event repeats the first producer");

endmodule

`default_nettype wire
